>>> rtl/pcp_pkg.sv
// Shared constants, types and tables for the parametric curve point generator.
// Used by pcp_phase, pcp_cordic, pcp_shape and parametric_curve_point.
package pcp_pkg;

  localparam int FRAC_BITS = 12;
  localparam int TRIG_ITER = 16;
  localparam int ATAN_N    = 24;

  // CORDIC works on 30 fraction bits; sine and cosine leave with FRAC_BITS
  localparam int CORD_W  = 32;
  localparam int RND_SH  = 30 - FRAC_BITS;
  localparam int TRIG_W  = FRAC_BITS + 2;
  localparam logic signed [CORD_W-1:0] CORDIC_X0 = 32'sd652032874;

  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // Phase in turns: the product is kept mod 2^(32 + PH_SH)
  localparam int T_W    = 18;
  localparam int PH_SH  = FRAC_BITS + 8;
  localparam int SUM_W  = 32 + PH_SH;
  localparam int LO_W   = 21;
  localparam int HI_W   = 20;
  localparam logic [63:0] K1  = 64'd174992710548;
  localparam logic [63:0] K2  = 2 * K1;
  localparam logic [63:0] K3  = 3 * K1;
  localparam logic [63:0] K11 = 11 * K1;
  localparam logic [HI_W-1:0] K1_HI  = HI_W'(K1 >> LO_W);
  localparam logic [LO_W-1:0] K1_LO  = LO_W'(K1);
  localparam logic [HI_W-1:0] K2_HI  = HI_W'(K2 >> LO_W);
  localparam logic [LO_W-1:0] K2_LO  = LO_W'(K2);
  localparam logic [HI_W-1:0] K3_HI  = HI_W'(K3 >> LO_W);
  localparam logic [LO_W-1:0] K3_LO  = LO_W'(K3);
  localparam logic [HI_W-1:0] K11_HI = HI_W'(K11 >> LO_W);
  localparam logic [LO_W-1:0] K11_LO = LO_W'(K11);

  // Remainder corrections for the fractional multipliers 11/6 and 2/3
  localparam logic [SUM_W-1:0] C11_TAB [6] = '{
    SUM_W'(0), SUM_W'(K11 / 6), SUM_W'((2 * K11) / 6), SUM_W'((3 * K11) / 6),
    SUM_W'((4 * K11) / 6), SUM_W'((5 * K11) / 6)
  };
  localparam logic [SUM_W-1:0] C23_TAB [3] = '{
    SUM_W'(0), SUM_W'(K2 / 3), SUM_W'((2 * K2) / 3)
  };

  // Reciprocals for t / 6 and t / 3, exact for t below 2^19
  localparam int RCP_SH = 20;
  localparam logic [17:0] RCP6 = 18'd174763;
  localparam logic [18:0] RCP3 = 19'd349526;

  // Reciprocal for m / 10, exact for m below 2^22
  localparam int RCP10_SH = 23;
  localparam logic [19:0] RCP10 = 20'd838861;

  localparam logic [3:0] SHAPE_ASTROID  = 4'd0;
  localparam logic [3:0] SHAPE_CYCLOID  = 4'd1;
  localparam logic [3:0] SHAPE_HUYGENS  = 4'd2;
  localparam logic [3:0] SHAPE_HYPO     = 4'd3;
  localparam logic [3:0] SHAPE_LINE     = 4'd4;
  localparam logic [3:0] SHAPE_CIRCLE   = 4'd5;
  localparam logic [3:0] SHAPE_ELLIPSE  = 4'd6;
  localparam logic [3:0] SHAPE_TROCHOID = 4'd7;
  localparam logic [3:0] SHAPE_STAR     = 4'd8;

  localparam logic [1:0] REG_SHAPE = 2'd0;
  localparam logic [1:0] REG_GAIN  = 2'd1;
  localparam logic [1:0] REG_CX    = 2'd2;
  localparam logic [1:0] REG_CY    = 2'd3;

  // Multiplier of t for the second trig lane
  typedef enum logic [1:0] {
    K_TWO, K_THREE, K_ELEVEN_SIXTH, K_TWO_THIRD
  } ksel_t;

  typedef enum logic [1:0] {
    DEN_ONE, DEN_TWO, DEN_TEN
  } den_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c1;
    logic signed [TRIG_W-1:0] s1;
    logic signed [TRIG_W-1:0] c2;
    logic signed [TRIG_W-1:0] s2;
  } trig_t;

endpackage

>>> rtl/pcp_phase.sv
// Phase generator: turns t into two 32-bit phases in turns (k = 1 and k from ksel).
// Three register stages. Depends on pcp_pkg.
module pcp_phase (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ce,
  input  logic                        in_valid,
  input  logic [pcp_pkg::T_W-1:0]     t,
  input  pcp_pkg::ksel_t              ksel,
  output logic                        out_valid,
  output logic [pcp_pkg::T_W-1:0]     t_out,
  output logic [31:0]                 phase1,
  output logic [31:0]                 phase2
);
  import pcp_pkg::*;

  logic [2:0]        vld;
  logic [T_W-1:0]    t1, t2;
  logic [15:0]       a6;
  logic [16:0]       a3;
  logic [37:0]       p6, p3;
  logic [T_W-1:0]    m6, m3;
  logic [2:0]        b6;
  logic [1:0]        b3;
  logic [T_W-1:0]    a_sel;
  logic [HI_W-1:0]   mhi;
  logic [LO_W-1:0]   mlo;
  logic [SUM_W-1:0]  c_sel, c2r;
  logic [37:0]       pp1h, pp2h;
  logic [38:0]       pp1l, pp2l;
  logic [SUM_W-1:0]  sum1, sum2;

  // Quotients t / 6 and t / 3 by reciprocal multiplication
  assign p6 = 38'(t) * 38'(RCP6);
  assign p3 = 38'(t) * 38'(RCP3);

  // Remainders, lane-two operand and correction
  always_comb begin
    m6 = T_W'(a6) * T_W'(6);
    m3 = T_W'(a3) * T_W'(3);
    b6 = 3'(t1 - m6);
    b3 = 2'(t1 - m3);
    a_sel = t1;
    mhi   = K2_HI;
    mlo   = K2_LO;
    c_sel = '0;
    case (ksel)
      K_THREE: begin
        mhi = K3_HI;
        mlo = K3_LO;
      end
      K_ELEVEN_SIXTH: begin
        a_sel = T_W'(a6);
        mhi   = K11_HI;
        mlo   = K11_LO;
        c_sel = (b6 < 3'd6) ? C11_TAB[b6] : '0;
      end
      K_TWO_THIRD: begin
        a_sel = T_W'(a3);
        c_sel = (b3 < 2'd3) ? C23_TAB[b3] : '0;
      end
      default: ;
    endcase
  end

  // Recombine partial products, keep bits of the turn
  assign sum1 = SUM_W'({pp1h, {LO_W{1'b0}}}) + SUM_W'(pp1l);
  assign sum2 = SUM_W'({pp2h, {LO_W{1'b0}}}) + SUM_W'(pp2l) + c2r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    if (ce) begin
      t1     <= t;
      a6     <= p6[RCP_SH+15:RCP_SH];
      a3     <= p3[RCP_SH+16:RCP_SH];
      t2     <= t1;
      pp1h   <= 38'(t1) * 38'(K1_HI);
      pp1l   <= 39'(t1) * 39'(K1_LO);
      pp2h   <= 38'(a_sel) * 38'(mhi);
      pp2l   <= 39'(a_sel) * 39'(mlo);
      c2r    <= c_sel;
      t_out  <= t2;
      phase1 <= sum1[SUM_W-1:PH_SH];
      phase2 <= sum2[SUM_W-1:PH_SH];
    end
  end

  assign out_valid = vld[2];

endmodule

>>> rtl/pcp_cordic.sv
// Two-lane pipelined rotation CORDIC: quadrant fold, TRIG_ITER stages, round.
// Depends on pcp_pkg.
module pcp_cordic (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ce,
  input  logic                     in_valid,
  input  logic [pcp_pkg::T_W-1:0]  t,
  input  logic [31:0]              phase1,
  input  logic [31:0]              phase2,
  output logic                     out_valid,
  output logic [pcp_pkg::T_W-1:0]  t_out,
  output pcp_pkg::trig_t           trig
);
  import pcp_pkg::*;

  localparam int N = TRIG_ITER;

  logic                     vld [N+2];
  logic [T_W-1:0]           ts  [N+1];
  logic signed [CORD_W-1:0] xs  [2][N+1];
  logic signed [CORD_W-1:0] ys  [2][N+1];
  logic signed [CORD_W-1:0] zs  [2][N+1];
  logic [1:0]               qs  [2][N+1];
  logic [31:0]              ph  [2];
  logic signed [TRIG_W-1:0] cr  [2];
  logic signed [TRIG_W-1:0] sr  [2];

  assign ph[0] = phase1;
  assign ph[1] = phase2;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N + 2; k++) vld[k] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
      for (int k = 1; k < N + 2; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ts[0] <= t;
      for (int k = 1; k <= N; k++) ts[k] <= ts[k-1];
      t_out <= ts[N];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [31:0]              qsum;
    logic [1:0]               q0;
    logic signed [CORD_W-1:0] cv, sv, cvr, svr;

    // Fold to the nearest quadrant, residual within one eighth turn
    assign qsum = ph[l] + 32'h2000_0000;
    assign q0   = qsum[31:30];

    always_ff @(posedge clk) begin
      if (ce) begin
        qs[l][0] <= q0;
        zs[l][0] <= $signed(ph[l] - {q0, 30'b0});
        xs[l][0] <= CORDIC_X0;
        ys[l][0] <= '0;
      end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
      always_ff @(posedge clk) begin
        if (ce) begin
          qs[l][i+1] <= qs[l][i];
          if (!zs[l][i][CORD_W-1]) begin
            xs[l][i+1] <= xs[l][i] - (ys[l][i] >>> i);
            ys[l][i+1] <= ys[l][i] + (xs[l][i] >>> i);
            zs[l][i+1] <= zs[l][i] - $signed(ATAN_TAB[i]);
          end else begin
            xs[l][i+1] <= xs[l][i] + (ys[l][i] >>> i);
            ys[l][i+1] <= ys[l][i] - (xs[l][i] >>> i);
            zs[l][i+1] <= zs[l][i] + $signed(ATAN_TAB[i]);
          end
        end
      end
    end

    // Rotate back by the quadrant and round half up
    always_comb begin
      case (qs[l][N])
        2'd0: begin
          cv = xs[l][N];
          sv = ys[l][N];
        end
        2'd1: begin
          cv = -ys[l][N];
          sv = xs[l][N];
        end
        2'd2: begin
          cv = -xs[l][N];
          sv = -ys[l][N];
        end
        default: begin
          cv = ys[l][N];
          sv = -xs[l][N];
        end
      endcase
      cvr = (cv + (CORD_W'(1) <<< (RND_SH - 1))) >>> RND_SH;
      svr = (sv + (CORD_W'(1) <<< (RND_SH - 1))) >>> RND_SH;
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        cr[l] <= cvr[TRIG_W-1:0];
        sr[l] <= svr[TRIG_W-1:0];
      end
    end
  end

  assign trig.c1   = cr[0];
  assign trig.s1   = sr[0];
  assign trig.c2   = cr[1];
  assign trig.s2   = sr[1];
  assign out_valid = vld[N+1];

endmodule

>>> rtl/pcp_shape.sv
// Curve formulas, gain and centre, truncating divide and saturation.
// Seven register stages, the last one is the output register. Depends on pcp_pkg.
module pcp_shape (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ce,
  input  logic                     in_valid,
  input  logic [pcp_pkg::T_W-1:0]  t,
  input  pcp_pkg::trig_t           trig,
  input  logic [3:0]               shape_select,
  input  logic [7:0]               scale_gain,
  input  logic [10:0]              center_x,
  input  logic [10:0]              center_y,
  output logic                     out_valid,
  output logic signed [15:0]       pixel_x,
  output logic signed [15:0]       pixel_y
);
  import pcp_pkg::*;

  localparam int NUM_W = 24;
  localparam int PRD_W = NUM_W + 9;
  localparam int CT_W  = 11 + 4 + FRAC_BITS;
  localparam int SUM_V = PRD_W + 2;
  localparam int MAG_W = SUM_V - FRAC_BITS;
  localparam logic signed [NUM_W-1:0] ONE = NUM_W'(1) <<< FRAC_BITS;

  function automatic logic signed [15:0] mulq(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    logic signed [31:0] p;
    p = a * b;
    if (p < 0) p = p + ((32'sd1 <<< FRAC_BITS) - 32'sd1);
    return 16'(p >>> FRAC_BITS);
  endfunction

  logic [6:0] vld;

  // Stage 1 registers
  trig_t                tr1;
  logic [T_W-1:0]       t1;
  logic signed [15:0]   cc, ss;
  // Stage 2 registers
  logic signed [NUM_W-1:0] nx, ny;
  den_t                    den2;
  // Stage 3 registers
  logic signed [PRD_W-1:0] prx, pry;
  logic [CT_W-1:0]         ctx, cty;
  den_t                    den3;
  // Stage 4 registers
  logic signed [SUM_V-1:0] vx, vy;
  den_t                    den4;
  // Stage 5 registers
  logic [MAG_W-1:0]        mx, my;
  logic                    ngx5, ngy5;
  den_t                    den5;
  // Stage 6 registers
  logic [MAG_W-1:0]        qx, qy;
  logic                    ngx6, ngy6;

  logic signed [NUM_W-1:0] c1, s1, c2, s2, ti, cubx, cuby, nx_n, ny_n;
  den_t                    den_n;
  logic [CT_W-1:0]         ctx_n, cty_n;
  logic [SUM_V-1:0]        ax, ay;
  logic [MAG_W-1:0]        qx_n, qy_n;
  logic [41:0]             rx, ry;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  // Curve coordinates as numerators over den
  always_comb begin
    c1   = NUM_W'(tr1.c1);
    s1   = NUM_W'(tr1.s1);
    c2   = NUM_W'(tr1.c2);
    s2   = NUM_W'(tr1.s2);
    ti   = $signed(NUM_W'(t1));
    cubx = NUM_W'(mulq(cc, 16'(tr1.c1)));
    cuby = NUM_W'(mulq(ss, 16'(tr1.s1)));
    nx_n  = '0;
    ny_n  = '0;
    den_n = DEN_ONE;
    case (shape_select)
      SHAPE_ASTROID: begin
        nx_n = NUM_W'(2 * cubx);
        ny_n = NUM_W'(2 * cuby);
      end
      SHAPE_CYCLOID: begin
        nx_n  = NUM_W'(3 * (ONE - c1));
        ny_n  = NUM_W'(3 * (ti - s1));
        den_n = DEN_TWO;
      end
      SHAPE_HUYGENS: begin
        nx_n = NUM_W'(4 * (3 * c1 - c2));
        ny_n = NUM_W'(4 * (3 * s1 - s2));
      end
      SHAPE_HYPO: begin
        nx_n  = NUM_W'(3 * (2 * c1 + c2));
        ny_n  = NUM_W'(3 * (2 * s1 - s2));
        den_n = DEN_TWO;
      end
      SHAPE_LINE: begin
        nx_n = ONE - ti;
        ny_n = ONE - ti;
      end
      SHAPE_CIRCLE: begin
        nx_n = c1;
        ny_n = s1;
      end
      SHAPE_ELLIPSE: begin
        nx_n  = NUM_W'(20 * c1);
        ny_n  = NUM_W'(11 * s1);
        den_n = DEN_TEN;
      end
      SHAPE_TROCHOID: begin
        nx_n = NUM_W'(11 * c1 - 6 * c2);
        ny_n = NUM_W'(11 * s1 - 6 * s2);
      end
      SHAPE_STAR: begin
        nx_n = NUM_W'(2 * c1 + 5 * c2);
        ny_n = NUM_W'(2 * s1 - 5 * s2);
      end
      default: ;
    endcase
  end

  // Centre scaled to the same denominator
  always_comb begin
    case (den2)
      DEN_TWO: begin
        ctx_n = CT_W'(center_x) << (FRAC_BITS + 1);
        cty_n = CT_W'(center_y) << (FRAC_BITS + 1);
      end
      DEN_TEN: begin
        ctx_n = ((CT_W'(center_x) << 3) + (CT_W'(center_x) << 1)) << FRAC_BITS;
        cty_n = ((CT_W'(center_y) << 3) + (CT_W'(center_y) << 1)) << FRAC_BITS;
      end
      default: begin
        ctx_n = CT_W'(center_x) << FRAC_BITS;
        cty_n = CT_W'(center_y) << FRAC_BITS;
      end
    endcase
  end

  // Magnitudes for the truncating divide
  assign ax = vx[SUM_V-1] ? SUM_V'(-vx) : SUM_V'(vx);
  assign ay = vy[SUM_V-1] ? SUM_V'(-vy) : SUM_V'(vy);

  // Divide the magnitude by den
  always_comb begin
    rx = 42'(mx) * 42'(RCP10);
    ry = 42'(my) * 42'(RCP10);
    case (den5)
      DEN_TWO: begin
        qx_n = mx >> 1;
        qy_n = my >> 1;
      end
      DEN_TEN: begin
        qx_n = MAG_W'(rx >> RCP10_SH);
        qy_n = MAG_W'(ry >> RCP10_SH);
      end
      default: begin
        qx_n = mx;
        qy_n = my;
      end
    endcase
  end

  function automatic logic signed [15:0] sat(input logic [MAG_W-1:0] m, input logic neg);
    logic signed [MAG_W:0] v;
    v = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Advance every stage together
  always_ff @(posedge clk) begin
    if (ce) begin
      tr1  <= trig;
      t1   <= t;
      cc   <= mulq(16'(trig.c1), 16'(trig.c1));
      ss   <= mulq(16'(trig.s1), 16'(trig.s1));
      nx   <= nx_n;
      ny   <= ny_n;
      den2 <= den_n;
      prx  <= PRD_W'(nx) * $signed({1'b0, scale_gain});
      pry  <= PRD_W'(ny) * $signed({1'b0, scale_gain});
      ctx  <= ctx_n;
      cty  <= cty_n;
      den3 <= den2;
      vx   <= SUM_V'(prx) + $signed(SUM_V'(ctx));
      vy   <= SUM_V'(pry) + $signed(SUM_V'(cty));
      den4 <= den3;
      mx   <= ax[SUM_V-1:FRAC_BITS];
      my   <= ay[SUM_V-1:FRAC_BITS];
      ngx5 <= vx[SUM_V-1];
      ngy5 <= vy[SUM_V-1];
      den5 <= den4;
      qx   <= qx_n;
      qy   <= qy_n;
      ngx6 <= ngx5;
      ngy6 <= ngy5;
      pixel_x <= sat(qx, ngx6);
      pixel_y <= sat(qy, ngy6);
    end
  end

  assign out_valid = vld[6];

endmodule

>>> rtl/parametric_curve_point.sv
// Parametric curve point generator, top level: config registers and pipeline.
// Depends on pcp_pkg, pcp_phase, pcp_cordic and pcp_shape.
//
//   Channel   Direction  Signals                       Payload
//   s_*       in         s_tvalid s_tready s_tdata     angle_param
//   m_*       out        m_tvalid m_tready m_tdata     pixel_x, pixel_y
//   cfg_*     in         cfg_we cfg_index cfg_data     register writes
//
// One transaction enters per cycle while the pipeline is not held.
// Each result passes the phase stages, the 16 CORDIC stages and the scaling stages.
// The whole pipeline advances together; it holds while m_tvalid is high and
// m_tready low, and s_tready follows that enable.
// Reset clears valid bits and loads register defaults.
module parametric_curve_point (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [17:0] angle_param
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] pixel_x, [31:16] pixel_y
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import pcp_pkg::*;

  logic [3:0]  shape_select;
  logic [7:0]  scale_gain;
  logic [10:0] center_x;
  logic [10:0] center_y;

  logic               ce;
  ksel_t              ksel;
  logic               ph_valid, co_valid;
  logic [T_W-1:0]     ph_t, co_t;
  logic [31:0]        phase1, phase2;
  trig_t              trig;
  logic signed [15:0] pixel_x, pixel_y;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_select <= 4'd0;
      scale_gain   <= 8'd90;
      center_x     <= 11'd200;
      center_y     <= 11'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHAPE: shape_select <= cfg_data[3:0];
        REG_GAIN:  scale_gain   <= cfg_data[7:0];
        REG_CX:    center_x     <= cfg_data;
        REG_CY:    center_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the second angle multiplier for the curve
  always_comb begin
    case (shape_select)
      SHAPE_HUYGENS:  ksel = K_THREE;
      SHAPE_TROCHOID: ksel = K_ELEVEN_SIXTH;
      SHAPE_STAR:     ksel = K_TWO_THIRD;
      default:        ksel = K_TWO;
    endcase
  end

  // Advance the pipeline unless the output register is stuck
  assign ce       = m_tready | ~m_tvalid;
  assign s_tready = ce;

  pcp_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .t         (s_tdata[T_W-1:0]),
    .ksel      (ksel),
    .out_valid (ph_valid),
    .t_out     (ph_t),
    .phase1    (phase1),
    .phase2    (phase2)
  );

  pcp_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (ph_valid),
    .t         (ph_t),
    .phase1    (phase1),
    .phase2    (phase2),
    .out_valid (co_valid),
    .t_out     (co_t),
    .trig      (trig)
  );

  pcp_shape u_shape (
    .clk          (clk),
    .rst          (rst),
    .ce           (ce),
    .in_valid     (co_valid),
    .t            (co_t),
    .trig         (trig),
    .shape_select (shape_select),
    .scale_gain   (scale_gain),
    .center_x     (center_x),
    .center_y     (center_y),
    .out_valid    (m_tvalid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y)
  );

  assign m_tdata = {pixel_y, pixel_x};

endmodule
